/* sv/jvs_pkg.sv */
// Shared types and constants for the JSON value extent scanner.
// No dependencies; imported by the top level, the lexer and the checker.
package jvs_pkg;

	// Default configuration
	localparam int MAX_NEST_DEF    = 128;
	localparam int OFFSET_BITS_DEF = 16;

	// Width of the reported stop offset
	localparam int STOP_W = 16;

	// Byte codes that steer the scan
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	// Result status codes
	typedef enum logic [2:0] {
		ST_SCANNING    = 3'd0,
		ST_TERMINATOR  = 3'd1,
		ST_MISMATCH    = 3'd2,
		ST_TOO_DEEP    = 3'd3,
		ST_OPEN_STRING = 3'd4,
		ST_REGION_END  = 3'd5,
		ST_IGNORED     = 3'd6
	} status_t;

	// Closer stack access for one byte
	typedef struct packed {
		logic push;     // write the expected closer at the stack address
		logic pop;      // read the expected closer at the stack address
		logic bracket;  // closer kind to push: 1 = ']', 0 = '}'
	} stack_ctl_t;

	// Byte result before the popped closer is checked
	typedef struct packed {
		status_t            status;
		logic [STOP_W-1:0]  stop_at;       // offset to report without mismatch
		logic [STOP_W-1:0]  here;          // offset of this byte
		logic               pop;           // byte popped the closer stack
		logic               want_bracket;  // byte is ']' (else '}')
	} s1_t;

endpackage

/* sv/json_value_extent_scanner.sv */
// JSON value extent scanner
// Input channel (in_valid/in_ready): one byte of a JSON region per transaction,
// with start_scan marking the first byte of a value and region_last the final
// byte of the region. Output channel (out_valid/out_ready): exactly one result
// per input byte: status, stop_offset and expected_bracket.
// A scan ends on a top-level ',' or closer (status 1, offset of that byte), a
// closer mismatch (status 2, expected kind in expected_bracket), nesting too
// deep (3), a string open at region end (4) or region end (5, region length).
// Bytes after the end of a scan report status 6 until the next start_scan.
// Each byte passes the stage-one register, then the result register. Throughput:
// one byte per cycle while out_ready holds. The expected closer stack sits in a
// one-bit memory with a registered read port; a pop issues its read when the byte
// is taken; the compare against the popped closer happens in the following stage.
// Reset: the block comes up idle (every byte ignored until start_scan); the
// stack contents are not cleared, since only entries pushed in the same scan
// are ever read. When the receiver stalls, the result register holds, the
// stage behind it fills, and in_ready drops.
module json_value_extent_scanner
	import jvs_pkg::*;
#(
	parameter int MAX_NEST    = MAX_NEST_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              start_scan,
	input  logic [7:0]        data_byte,
	input  logic              region_last,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        status,
	output logic [STOP_W-1:0] stop_offset,
	output logic              expected_bracket
);

	localparam int DEPTH_W = $clog2(MAX_NEST);

	stack_ctl_t         stack_ctl;
	logic [DEPTH_W-1:0] stack_addr;
	logic               popped;
	s1_t                s1_next, s1_s1;
	logic               s1_valid_q;
	logic               accept, advance, mismatch;
	status_t            res_status;
	logic [STOP_W-1:0]  res_offset;
	logic               res_expect;
	logic               out_valid_q;
	status_t            status_q;
	logic [STOP_W-1:0]  stop_offset_q;
	logic               expected_q;

	assign advance  = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || advance;
	assign accept   = in_valid && in_ready;
	assign mismatch = s1_valid_q && s1_s1.pop && (popped != s1_s1.want_bracket);

	jvs_lexer #(
		.MAX_NEST    (MAX_NEST),
		.OFFSET_BITS (OFFSET_BITS),
		.DEPTH_W     (DEPTH_W)
	) u_lexer (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.start_scan  (start_scan),
		.data_byte   (data_byte),
		.region_last (region_last),
		.fin_force   (mismatch),
		.stack_ctl   (stack_ctl),
		.stack_addr  (stack_addr),
		.s1_next     (s1_next)
	);

	jvs_stack #(
		.DEPTH  (MAX_NEST),
		.ADDR_W (DEPTH_W)
	) u_stack (
		.clk     (clk),
		.wr_en   (stack_ctl.push),
		.wr_addr (stack_addr),
		.wr_data (stack_ctl.bracket),
		.rd_en   (stack_ctl.pop),
		.rd_addr (stack_addr),
		.rd_data (popped)
	);

	// Hold the classified byte while the stack read completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_s1 <= s1_next;
		end
	end

	// Resolve a closer mismatch against the popped entry
	always_comb begin
		if (mismatch) begin
			res_status = ST_MISMATCH;
			res_offset = s1_s1.here;
			res_expect = popped;
		end else begin
			res_status = s1_s1.status;
			res_offset = s1_s1.stop_at;
			res_expect = 1'b0;
		end
	end

	// Output register: load on advance, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q      <= res_status;
			stop_offset_q <= res_offset;
			expected_q    <= res_expect;
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign stop_offset      = stop_offset_q;
	assign expected_bracket = expected_q;

endmodule

/* sv/jvs_stack.sv */
// Closer stack storage: one-bit entries, one write and one registered read port.
// Depends on nothing but its parameters.
module jvs_stack #(
	parameter int DEPTH  = 128,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic              wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic              rd_data
);

	logic mem [DEPTH];
	logic rd_data_q;

	// Write the pushed closer kind
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read the popped entry; hold the data until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* sv/jvs_lexer.sv */
// Byte classifier and scan state: string/escape tracking, nesting depth, offset.
// Depends on jvs_pkg; drives the closer stack ports and the first pipeline stage.
module jvs_lexer
	import jvs_pkg::*;
#(
	parameter int MAX_NEST    = MAX_NEST_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF,
	parameter int DEPTH_W     = $clog2(MAX_NEST)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic               start_scan,
	input  logic [7:0]         data_byte,
	input  logic               region_last,
	input  logic               fin_force,   // byte in flight ended the scan on a mismatch
	output stack_ctl_t         stack_ctl,
	output logic [DEPTH_W-1:0] stack_addr,
	output s1_t                s1_next
);

	localparam logic [OFFSET_BITS-1:0] OFF_MAX  = {OFFSET_BITS{1'b1}};
	localparam logic [DEPTH_W-1:0]     DEPTH_TOP = DEPTH_W'(MAX_NEST - 1);

	logic                   in_str_q, esc_q, fin_q;
	logic [DEPTH_W-1:0]     depth_q;
	logic [OFFSET_BITS-1:0] off_q;

	logic                   in_str_c, esc_c, fin_c;
	logic [DEPTH_W-1:0]     depth_c;
	logic [OFFSET_BITS-1:0] off_c, off_inc;
	logic                   in_str_n, esc_n, fin_n;
	logic [DEPTH_W-1:0]     depth_n;
	logic [OFFSET_BITS-1:0] off_n;
	status_t                st;

	// Classify the byte and compute next scan state
	always_comb begin
		in_str_c = start_scan ? 1'b0 : in_str_q;
		esc_c    = start_scan ? 1'b0 : esc_q;
		depth_c  = start_scan ? '0 : depth_q;
		off_c    = start_scan ? '0 : off_q;
		fin_c    = start_scan ? 1'b0 : (fin_q | fin_force);
		off_inc  = (off_c == OFF_MAX) ? off_c : off_c + 1'b1;

		in_str_n   = in_str_c;
		esc_n      = esc_c;
		depth_n    = depth_c;
		off_n      = off_c;
		fin_n      = fin_c;
		st         = ST_SCANNING;
		stack_ctl  = '0;
		stack_addr = depth_c;

		s1_next              = '0;
		s1_next.want_bracket = (data_byte == CH_RBRACK);

		if (fin_c) begin
			st = ST_IGNORED;
		end else begin
			if (in_str_c) begin
				if (esc_c) begin
					esc_n = 1'b0;
				end else if (data_byte == CH_BSLASH) begin
					esc_n = 1'b1;
				end else if (data_byte == CH_QUOTE) begin
					in_str_n = 1'b0;
				end
			end else if (data_byte == CH_QUOTE) begin
				in_str_n = 1'b1;
				esc_n    = 1'b0;
			end else if (data_byte == CH_COMMA) begin
				if (depth_c == '0) begin
					st = ST_TERMINATOR;
				end
			end else if (data_byte == CH_LBRACE || data_byte == CH_LBRACK) begin
				if (depth_c == DEPTH_TOP) begin
					st = ST_TOO_DEEP;
				end else begin
					stack_ctl.push    = 1'b1;
					stack_ctl.bracket = (data_byte == CH_LBRACK);
					depth_n           = depth_c + 1'b1;
				end
			end else if (data_byte == CH_RBRACE || data_byte == CH_RBRACK) begin
				if (depth_c == '0) begin
					st = ST_TERMINATOR;
				end else begin
					stack_ctl.pop = 1'b1;
					depth_n       = depth_c - 1'b1;
					stack_addr    = depth_c - 1'b1;
				end
			end

			// Region end when nothing else stopped the scan
			s1_next.here    = STOP_W'(off_c);
			s1_next.stop_at = STOP_W'(off_c);
			if (st == ST_SCANNING && region_last) begin
				st              = in_str_n ? ST_OPEN_STRING : ST_REGION_END;
				s1_next.stop_at = STOP_W'(off_inc);
			end

			off_n = off_inc;
			fin_n = (st != ST_SCANNING);
		end

		s1_next.status = st;
		s1_next.pop    = stack_ctl.pop;
		stack_ctl.push = stack_ctl.push & accept;
		stack_ctl.pop  = stack_ctl.pop & accept;
	end

	// Update scan state on each transaction; fold in a late mismatch otherwise
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_str_q <= 1'b0;
			esc_q    <= 1'b0;
			depth_q  <= '0;
			off_q    <= '0;
			fin_q    <= 1'b1;
		end else if (accept) begin
			in_str_q <= in_str_n;
			esc_q    <= esc_n;
			depth_q  <= depth_n;
			off_q    <= off_n;
			fin_q    <= fin_n;
		end else begin
			fin_q <= fin_q | fin_force;
		end
	end

endmodule

/* sv/jvs_checker.sv */
// Port-level checks for the JSON value extent scanner, bound to the top level.
// Depends on jvs_pkg for the status codes.
module jvs_checker
	import jvs_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [2:0]        status,
	input logic [STOP_W-1:0] stop_offset,
	input logic              expected_bracket
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(stop_offset)
			&& $stable(expected_bracket))
		else $error("stalled result changed");

	// Expected closer kind only on a mismatch
	a_expect_only_mismatch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_MISMATCH |-> expected_bracket == 1'b0)
		else $error("expected_bracket set outside a mismatch");

	// Ignored bytes report offset zero
	a_ignored_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_IGNORED |-> stop_offset == '0)
		else $error("ignored byte with nonzero offset");

	// A fresh result traces back to an earlier input transaction
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a matching input transaction");

endmodule

bind json_value_extent_scanner jvs_checker u_jvs_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_ready         (in_ready),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.status           (status),
	.stop_offset      (stop_offset),
	.expected_bracket (expected_bracket)
);
